[src/cartridge_bank_mapper_defines.svh]
// Assertion macros shared by the checker of the cartridge bank mapper.
`ifndef CARTRIDGE_BANK_MAPPER_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_DEFINES_SVH

// The consequent is checked in the same cycle as the antecedent.
`define CBM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error("cartridge bank mapper check failed");

// The consequent is checked in the cycle after the antecedent.
`define CBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error("cartridge bank mapper check failed");

`endif

[src/cbm_pkg.sv]
// Shared constants, types and helpers of the cartridge bank mapper.
package cbm_pkg;

  localparam int unsigned ROM_BYTES     = 1048576;
  localparam int unsigned BANK_BYTES    = 16384;
  localparam int unsigned SYS_RAM_BYTES = 8192;
  localparam int unsigned CART_BYTES    = 2 * BANK_BYTES;

  localparam int unsigned ROM_AW  = $clog2(ROM_BYTES);
  localparam int unsigned BANK_AW = $clog2(BANK_BYTES);
  localparam int unsigned SYS_AW  = $clog2(SYS_RAM_BYTES);
  localparam int unsigned CART_AW = $clog2(CART_BYTES);

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned OFF_W   = 20;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned PAGE_W  = 6;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_LOAD  = 2'd2
  } cmd_e;

  localparam logic [CFG_IDX_W-1:0] CFG_ALT_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_MEG  = 1'b1;

  localparam logic [ADDR_W-1:0] ADDR_SLOT0     = 16'h0000;
  localparam logic [ADDR_W-1:0] ADDR_FIXED_END = 16'h0400;
  localparam logic [ADDR_W-1:0] ADDR_SLOT1     = 16'h4000;
  localparam logic [ADDR_W-1:0] ADDR_SLOT2     = 16'h8000;
  localparam logic [ADDR_W-1:0] ADDR_SYS_RAM   = 16'hC000;
  localparam logic [ADDR_W-1:0] ADDR_CTRL      = 16'hFFFC;
  localparam logic [ADDR_W-1:0] ADDR_PAGE0     = 16'hFFFD;
  localparam logic [ADDR_W-1:0] ADDR_PAGE1     = 16'hFFFE;
  localparam logic [ADDR_W-1:0] ADDR_PAGE2     = 16'hFFFF;

  localparam logic [PAGE_W-1:0] PAGE_MASK_WIDE   = 6'h3F;
  localparam logic [PAGE_W-1:0] PAGE_MASK_NARROW = 6'h1F;

  localparam logic [PAGE_W-1:0] PAGE0_RESET = PAGE_W'(0);
  localparam logic [PAGE_W-1:0] PAGE1_RESET = PAGE_W'(1);
  localparam logic [PAGE_W-1:0] PAGE2_RESET = PAGE_W'(2);

  typedef enum logic [1:0] {
    SRC_ROM,
    SRC_CART,
    SRC_SYS
  } src_e;

  // One access to the three memories, decoded from a request beat.
  typedef struct packed {
    logic              rom_we;
    logic              rom_re;
    logic [ROM_AW-1:0] rom_addr;
    logic              cart_we;
    logic              cart_re;
    logic [CART_AW-1:0] cart_addr;
    logic              sys_we;
    logic              sys_re;
    logic [SYS_AW-1:0] sys_addr;
    logic [DATA_W-1:0] wdata;
    src_e              src;
  } mem_req_t;

  // State of the power-up clearing pass.
  typedef struct packed {
    logic               active;
    logic [CART_AW-1:0] addr;
  } clr_t;

  // Linear ROM index of a page and an offset in it, wrapped to the ROM size.
  function automatic logic [ROM_AW-1:0] rom_index(logic [PAGE_W-1:0] page,
                                                  logic [BANK_AW-1:0] off);
    logic [PAGE_W+BANK_AW-1:0] lin;
    lin = {page, off};
    return ROM_AW'(lin);
  endfunction

endpackage

[src/cbm_req_if.sv]
// Request channel: bus commands and ROM load bytes.
interface cbm_req_if;
  logic                        valid;
  logic                        ready;
  logic [cbm_pkg::CMD_W-1:0]   command;
  logic [cbm_pkg::ADDR_W-1:0]  cpu_address;
  logic [cbm_pkg::OFF_W-1:0]   rom_offset;
  logic [cbm_pkg::DATA_W-1:0]  write_data;

  modport source (output valid, command, cpu_address, rom_offset, write_data,
                  input ready);
  modport sink (input valid, command, cpu_address, rom_offset, write_data,
                output ready);
endinterface

[src/cbm_rsp_if.sv]
// Response channel: bytes returned for bus reads.
interface cbm_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [cbm_pkg::DATA_W-1:0]  read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

[src/cbm_ram.sv]
// Generic single-port synchronous RAM with registered read data.
module cbm_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/cbm_clear.sv]
// Power-up sweep that zeroes the cartridge RAM and the system RAM.
module cbm_clear (
  input  logic          clk_i,
  input  logic          rst_ni,
  output cbm_pkg::clr_t clr_o
);

  logic [cbm_pkg::CART_AW-1:0] cnt_q, cnt_d;
  logic                        active_q, active_d;

  always_comb begin
    cnt_d    = cnt_q;
    active_d = active_q;
    if (active_q) begin
      cnt_d = cnt_q + 1'b1;
      if (&cnt_q) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      active_q <= 1'b1;
    end else begin
      cnt_q    <= cnt_d;
      active_q <= active_d;
    end
  end

  assign clr_o.active = active_q;
  assign clr_o.addr   = cnt_q;

endmodule

[src/cbm_map.sv]
// Mapper registers and the decode of a request beat into memory accesses.
module cbm_map (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic                             cfg_data_i,
  input  logic                             beat_i,
  input  logic [cbm_pkg::CMD_W-1:0]        command_i,
  input  logic [cbm_pkg::ADDR_W-1:0]       cpu_address_i,
  input  logic [cbm_pkg::OFF_W-1:0]        rom_offset_i,
  input  logic [cbm_pkg::DATA_W-1:0]       write_data_i,
  output cbm_pkg::mem_req_t                req_o
);

  logic                        alt_mode_q, alt_mode_d;
  logic                        one_meg_q, one_meg_d;
  logic [cbm_pkg::PAGE_W-1:0]  page0_q, page0_d;
  logic [cbm_pkg::PAGE_W-1:0]  page1_q, page1_d;
  logic [cbm_pkg::PAGE_W-1:0]  page2_q, page2_d;
  logic                        lock_q, lock_d;
  logic                        ram_en_q, ram_en_d;
  logic                        ram_bank_q, ram_bank_d;

  logic                        is_read;
  logic                        is_write;
  logic                        is_load;
  logic [cbm_pkg::BANK_AW-1:0] bank_off;
  logic [cbm_pkg::PAGE_W-1:0]  std_page;
  logic [cbm_pkg::PAGE_W-1:0]  alt_page;

  assign is_read  = beat_i && (command_i == cbm_pkg::CMD_READ);
  assign is_write = beat_i && (command_i == cbm_pkg::CMD_WRITE);
  assign is_load  = beat_i && (command_i == cbm_pkg::CMD_LOAD);
  assign bank_off = cpu_address_i[cbm_pkg::BANK_AW-1:0];
  assign std_page = write_data_i[cbm_pkg::PAGE_W-1:0]
                    & (one_meg_q ? cbm_pkg::PAGE_MASK_WIDE : cbm_pkg::PAGE_MASK_NARROW);
  assign alt_page = write_data_i[cbm_pkg::PAGE_W-1:0] & cbm_pkg::PAGE_MASK_NARROW;

  // Memory access decode; reads see the mapper registers as they were before this beat.
  always_comb begin
    req_o          = '0;
    req_o.src      = cbm_pkg::SRC_ROM;
    req_o.wdata    = write_data_i;
    req_o.sys_addr = cpu_address_i[cbm_pkg::SYS_AW-1:0];
    req_o.cart_addr = {ram_bank_q, bank_off};
    if (is_load) begin
      req_o.rom_we   = 1'b1;
      req_o.rom_addr = cbm_pkg::ROM_AW'(rom_offset_i);
    end else if (cpu_address_i >= cbm_pkg::ADDR_SYS_RAM) begin
      req_o.sys_re = is_read;
      req_o.sys_we = is_write;
      req_o.src    = cbm_pkg::SRC_SYS;
    end else if (cpu_address_i >= cbm_pkg::ADDR_SLOT2) begin
      if (ram_en_q) begin
        req_o.cart_re = is_read;
        req_o.cart_we = is_write;
        req_o.src     = cbm_pkg::SRC_CART;
      end else begin
        req_o.rom_re   = is_read;
        req_o.rom_addr = cbm_pkg::rom_index(page2_q, bank_off);
      end
    end else if (cpu_address_i >= cbm_pkg::ADDR_SLOT1) begin
      req_o.rom_re   = is_read;
      req_o.rom_addr = cbm_pkg::rom_index(page1_q, bank_off);
    end else if (!alt_mode_q && (cpu_address_i < cbm_pkg::ADDR_FIXED_END)) begin
      req_o.rom_re   = is_read;
      req_o.rom_addr = cbm_pkg::rom_index('0, bank_off);
    end else begin
      req_o.rom_re   = is_read;
      req_o.rom_addr = cbm_pkg::rom_index(page0_q, bank_off);
    end
  end

  always_comb begin
    alt_mode_d = alt_mode_q;
    one_meg_d  = one_meg_q;
    page0_d    = page0_q;
    page1_d    = page1_q;
    page2_d    = page2_q;
    lock_d     = lock_q;
    ram_en_d   = ram_en_q;
    ram_bank_d = ram_bank_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        cbm_pkg::CFG_ALT_MODE: alt_mode_d = cfg_data_i;
        cbm_pkg::CFG_ONE_MEG:  one_meg_d  = cfg_data_i;
        default: ;
      endcase
    end
    if (is_write) begin
      if (alt_mode_q) begin
        case (cpu_address_i)
          cbm_pkg::ADDR_SLOT0: page0_d = alt_page;
          cbm_pkg::ADDR_SLOT1: page1_d = alt_page;
          cbm_pkg::ADDR_SLOT2: page2_d = alt_page;
          default: ;
        endcase
      end
      if (cpu_address_i == cbm_pkg::ADDR_CTRL) begin
        lock_d = write_data_i[3];
      end
      if (!alt_mode_q) begin
        case (cpu_address_i)
          cbm_pkg::ADDR_CTRL: begin
            ram_en_d   = write_data_i[3];
            ram_bank_d = write_data_i[3] & write_data_i[2];
          end
          cbm_pkg::ADDR_PAGE0: page0_d = std_page;
          cbm_pkg::ADDR_PAGE1: page1_d = std_page;
          cbm_pkg::ADDR_PAGE2: begin
            // Slot two paging is frozen while the control byte enables RAM.
            if (!lock_q) begin
              page2_d = std_page;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_mode_q <= 1'b0;
      one_meg_q  <= 1'b0;
      page0_q    <= cbm_pkg::PAGE0_RESET;
      page1_q    <= cbm_pkg::PAGE1_RESET;
      page2_q    <= cbm_pkg::PAGE2_RESET;
      lock_q     <= 1'b0;
      ram_en_q   <= 1'b0;
      ram_bank_q <= 1'b0;
    end else begin
      alt_mode_q <= alt_mode_d;
      one_meg_q  <= one_meg_d;
      page0_q    <= page0_d;
      page1_q    <= page1_d;
      page2_q    <= page2_d;
      lock_q     <= lock_d;
      ram_en_q   <= ram_en_d;
      ram_bank_q <= ram_bank_d;
    end
  end

endmodule

[src/cartridge_bank_mapper.sv]
// Top level of the cartridge bank mapper: channels, memories and read pipeline.
//
// Usage: requests arrive on req_i with a valid/ready handshake; each beat is a
// bus read, a bus write or a ROM load byte. Only bus reads produce a response
// beat on rsp_o, carrying the byte read. Writes and loads complete silently.
// Mapper options are set through cfg_we_i/cfg_index_i/cfg_data_i while idle;
// it is the user who must keep to this, as the block does not enforce it.
// Reads pass the synchronous memory lookup and then the output register.
// Throughput: one request beat per cycle while req_i.ready is high; each beat is
// at most one access to the ROM, cartridge RAM or system RAM port, and a write
// updates memory at the same edge so the next beat already sees it.
// Reset: the mapper registers take their power-up pages and the cartridge RAM
// and system RAM are zeroed by a sweep (one entry per cycle), during which
// req_i.ready stays low. ROM contents are not cleared.
// Backpressure: when rsp_o is stalled, one read waits in the memory stage and
// one in the output register; req_i.ready drops once both are occupied.
module cartridge_bank_mapper (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cbm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic                          cfg_data_i,
  cbm_req_if.sink                       req_i,
  cbm_rsp_if.source                     rsp_o
);

  cbm_pkg::mem_req_t mreq;
  cbm_pkg::clr_t     clr;

  logic                        accept;
  logic                        rd_advance;
  logic                        rd_valid_q, rd_valid_d;
  cbm_pkg::src_e               rd_src_q, rd_src_d;
  logic                        out_valid_q, out_valid_d;
  logic [cbm_pkg::DATA_W-1:0]  out_data_q, out_data_d;
  logic [cbm_pkg::DATA_W-1:0]  rom_rdata, cart_rdata, sys_rdata;
  logic [cbm_pkg::DATA_W-1:0]  rd_mux;

  logic                        cart_we, sys_we;
  logic [cbm_pkg::CART_AW-1:0] cart_addr;
  logic [cbm_pkg::SYS_AW-1:0]  sys_addr;
  logic [cbm_pkg::DATA_W-1:0]  clr_wdata_cart, clr_wdata_sys;

  assign rd_advance  = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !clr.active && (!rd_valid_q || rd_advance);
  assign accept      = req_i.valid && req_i.ready;

  cbm_clear u_clear (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_o  (clr)
  );

  cbm_map u_map (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .beat_i        (accept),
    .command_i     (req_i.command),
    .cpu_address_i (req_i.cpu_address),
    .rom_offset_i  (req_i.rom_offset),
    .write_data_i  (req_i.write_data),
    .req_o         (mreq)
  );

  // The clearing sweep owns the RAM ports until it finishes.
  assign cart_we        = clr.active || mreq.cart_we;
  assign cart_addr      = clr.active ? clr.addr : mreq.cart_addr;
  assign clr_wdata_cart = clr.active ? '0 : mreq.wdata;
  assign sys_we         = clr.active || mreq.sys_we;
  assign sys_addr       = clr.active ? clr.addr[cbm_pkg::SYS_AW-1:0] : mreq.sys_addr;
  assign clr_wdata_sys  = clr.active ? '0 : mreq.wdata;

  cbm_ram #(
    .DEPTH (cbm_pkg::ROM_BYTES),
    .WIDTH (cbm_pkg::DATA_W)
  ) u_rom (
    .clk_i   (clk_i),
    .we_i    (mreq.rom_we),
    .re_i    (mreq.rom_re),
    .addr_i  (mreq.rom_addr),
    .wdata_i (mreq.wdata),
    .rdata_o (rom_rdata)
  );

  cbm_ram #(
    .DEPTH (cbm_pkg::CART_BYTES),
    .WIDTH (cbm_pkg::DATA_W)
  ) u_cart (
    .clk_i   (clk_i),
    .we_i    (cart_we),
    .re_i    (mreq.cart_re),
    .addr_i  (cart_addr),
    .wdata_i (clr_wdata_cart),
    .rdata_o (cart_rdata)
  );

  cbm_ram #(
    .DEPTH (cbm_pkg::SYS_RAM_BYTES),
    .WIDTH (cbm_pkg::DATA_W)
  ) u_sys (
    .clk_i   (clk_i),
    .we_i    (sys_we),
    .re_i    (mreq.sys_re),
    .addr_i  (sys_addr),
    .wdata_i (clr_wdata_sys),
    .rdata_o (sys_rdata)
  );

  always_comb begin
    case (rd_src_q)
      cbm_pkg::SRC_CART: rd_mux = cart_rdata;
      cbm_pkg::SRC_SYS:  rd_mux = sys_rdata;
      default:           rd_mux = rom_rdata;
    endcase
  end

  // A memory read keeps its data until the next read, which only starts once
  // this one has moved into the output register.
  always_comb begin
    rd_valid_d  = rd_valid_q;
    rd_src_d    = rd_src_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (rd_valid_q && rd_advance) begin
      out_valid_d = 1'b1;
      out_data_d  = rd_mux;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (accept && (req_i.command == cbm_pkg::CMD_READ)) begin
      rd_valid_d = 1'b1;
      rd_src_d   = mreq.src;
    end else if (rd_advance) begin
      rd_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      rd_src_q    <= cbm_pkg::SRC_ROM;
      out_valid_q <= 1'b0;
    end else begin
      rd_valid_q  <= rd_valid_d;
      rd_src_q    <= rd_src_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_data_q;

endmodule

[src/cbm_checker.sv]
// Port-level checks of the cartridge bank mapper, bound to the top level.
`include "cartridge_bank_mapper_defines.svh"

module cbm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic [cbm_pkg::CMD_W-1:0]     req_command_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [cbm_pkg::DATA_W-1:0]    rsp_read_data_i
);

  logic read_beat;

  assign read_beat = req_valid_i && req_ready_i && (req_command_i == cbm_pkg::CMD_READ);

  // The clearing sweep holds off requests right after reset.
  `CBM_ASSERT_NOW(a_clear_blocks, $rose(rst_ni), !req_ready_i)

  // A read taken with rsp_o empty is answered via the output register.
  `CBM_ASSERT_NOW(a_read_latency, read_beat && !rsp_valid_i, ##2 rsp_valid_i)

  `CBM_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i)

  `CBM_ASSERT_NEXT(a_rsp_stable, rsp_valid_i && !rsp_ready_i, $stable(rsp_read_data_i))

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .req_command_i   (req_i.command),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_read_data_i (rsp_o.read_data)
);

[test/cartridge_bank_mapper_test.sv]
// Self-checking testbench of the cartridge bank mapper: directed and random bus traffic.
module cartridge_bank_mapper_test;
  import cbm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int PLAN = 0;
  localparam int LIVE = 1;
  localparam int CTRL_RAM_EN = 3;
  localparam int CTRL_BANK = 2;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PHASE_BEATS = 225;
  localparam int RANDOM_PHASES = 6;

  typedef enum int {
    IDLE_SEND_LIGHT,
    IDLE_SEND_HEAVY,
    IDLE_NONE
  } idle_mode_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] addr;
    logic [OFF_W-1:0]  off;
    logic [DATA_W-1:0] data;
  } bus_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic cfg_data_i;

  cbm_req_if req_bus ();
  cbm_rsp_if rsp_bus ();

  cartridge_bank_mapper u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  always #2 clk_i = ~clk_i;

  // The paging registers exist twice: the PLAN copy follows the beats as they are
  // queued, so that the stimulus never reads a ROM byte that was not loaded; the
  // LIVE copy follows the beats as the block accepts them and gives the prediction.
  logic alt_mode [2];
  logic wide_pages [2];
  logic [DATA_W-1:0] ctrl_reg [2];
  logic [PAGE_W-1:0] page0 [2];
  logic [PAGE_W-1:0] page1 [2];
  logic [PAGE_W-1:0] page2 [2];
  logic [1:0] bank_sel [2];

  logic [DATA_W-1:0] rom_img [ROM_BYTES];
  bit rom_loaded [ROM_BYTES];
  logic [DATA_W-1:0] cart_img [CART_BYTES];
  logic [DATA_W-1:0] sys_img [SYS_RAM_BYTES];

  bus_beat_t pending_beats [$];
  logic [DATA_W-1:0] read_bytes_due [$];
  logic [ADDR_W-1:0] recent_reads [$];

  int beats_counted = 0;
  int err_count = 0;
  int send_quiet = 0;
  int recv_quiet = 0;
  idle_mode_e idle_mode = IDLE_SEND_LIGHT;

  function automatic src_e map_read(int s, logic [ADDR_W-1:0] a,
                                    output logic [OFF_W-1:0] idx);
    if (a >= ADDR_SYS_RAM) begin
      idx = OFF_W'(a[SYS_AW-1:0]);
      return SRC_SYS;
    end
    if (a < ADDR_SLOT1) begin
      // Standard mode pins the first kilobyte to ROM page 0.
      idx = {(!alt_mode[s] && a < ADDR_FIXED_END) ? PAGE_W'(0) : page0[s],
             a[BANK_AW-1:0]};
      return SRC_ROM;
    end
    if (a < ADDR_SLOT2) begin
      idx = {page1[s], a[BANK_AW-1:0]};
      return SRC_ROM;
    end
    if (bank_sel[s][1]) begin
      idx = OFF_W'({bank_sel[s][0], a[BANK_AW-1:0]});
      return SRC_CART;
    end
    idx = {page2[s], a[BANK_AW-1:0]};
    return SRC_ROM;
  endfunction

  function automatic void update_mapper(int s, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    logic [PAGE_W-1:0] pg;
    if (alt_mode[s]) begin
      if (a == ADDR_SLOT0) page0[s] = d[PAGE_W-1:0] & PAGE_MASK_NARROW;
      else if (a == ADDR_SLOT1) page1[s] = d[PAGE_W-1:0] & PAGE_MASK_NARROW;
      else if (a == ADDR_SLOT2) page2[s] = d[PAGE_W-1:0] & PAGE_MASK_NARROW;
    end
    if (a >= ADDR_SLOT2 && a < ADDR_SYS_RAM) begin
      if (s == LIVE && bank_sel[s][1]) cart_img[{bank_sel[s][0], a[BANK_AW-1:0]}] = d;
    end else if (a >= ADDR_SYS_RAM) begin
      if (s == LIVE) sys_img[a[SYS_AW-1:0]] = d;
      if (a == ADDR_CTRL) ctrl_reg[s] = d;
      if (a >= ADDR_CTRL && !alt_mode[s]) begin
        pg = d[PAGE_W-1:0] & (wide_pages[s] ? PAGE_MASK_WIDE : PAGE_MASK_NARROW);
        case (a)
          ADDR_CTRL: begin
            bank_sel[s] = d[CTRL_RAM_EN] ? {1'b1, d[CTRL_BANK]} : 2'b00;
          end
          ADDR_PAGE0: page0[s] = pg;
          ADDR_PAGE1: page1[s] = pg;
          default: begin
            // Slot two paging is locked while cartridge RAM is enabled.
            if (!ctrl_reg[s][CTRL_RAM_EN]) page2[s] = pg;
          end
        endcase
      end
    end
  endfunction

  function automatic logic [DATA_W-1:0] bus_byte(logic [ADDR_W-1:0] a);
    logic [OFF_W-1:0] idx;
    src_e src;
    src = map_read(LIVE, a, idx);
    case (src)
      SRC_SYS:  return sys_img[idx[SYS_AW-1:0]];
      SRC_CART: return cart_img[idx[CART_AW-1:0]];
      default:  return rom_img[idx];
    endcase
  endfunction

  function automatic void predict_beat(bus_beat_t b);
    case (b.command)
      CMD_READ:  read_bytes_due.push_back(bus_byte(b.addr));
      CMD_WRITE: update_mapper(LIVE, b.addr, b.data);
      CMD_LOAD:  rom_img[b.off] = b.data;
      default: ;
    endcase
  endfunction

  function automatic bus_beat_t make_beat(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a,
                                          logic [OFF_W-1:0] o, logic [DATA_W-1:0] d);
    bus_beat_t b;
    b.command = c;
    b.addr = a;
    b.off = o;
    b.data = d;
    return b;
  endfunction

  function automatic void queue_beat(bus_beat_t b);
    if (b.command == CMD_WRITE) update_mapper(PLAN, b.addr, b.data);
    else if (b.command == CMD_LOAD) rom_loaded[b.off] = 1'b1;
    if (b.command != CMD_UNUSED) beats_counted++;
    pending_beats.push_back(b);
  endfunction

  function automatic void queue_load(logic [OFF_W-1:0] o, logic [DATA_W-1:0] d);
    queue_beat(make_beat(CMD_LOAD, ADDR_W'($urandom), o, d));
  endfunction

  function automatic void queue_write(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    queue_beat(make_beat(CMD_WRITE, a, OFF_W'($urandom), d));
  endfunction

  // A read that lands on a ROM byte not yet loaded gets a load beat in front of it.
  function automatic void queue_read(logic [ADDR_W-1:0] a);
    logic [OFF_W-1:0] idx;
    src_e src;
    src = map_read(PLAN, a, idx);
    if (src == SRC_ROM && !rom_loaded[idx]) queue_load(idx, DATA_W'($urandom));
    queue_beat(make_beat(CMD_READ, a, OFF_W'($urandom), DATA_W'($urandom)));
    recent_reads.push_back(a);
    if (recent_reads.size() > 16) void'(recent_reads.pop_front());
  endfunction

  function automatic void random_traffic(int n);
    int stop;
    int pick;
    int slot;
    bit alt_style;
    logic [ADDR_W-1:0] a;
    logic [OFF_W-1:0] idx;
    logic [DATA_W-1:0] d;
    src_e src;
    stop = beats_counted + n;
    while (beats_counted < stop) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        if (recent_reads.size() != 0 && $urandom_range(2) == 0)
          a = recent_reads[$urandom_range(recent_reads.size() - 1)];
        else
          a = ADDR_W'($urandom);
        queue_read(a);
      end else if (pick < 40) begin
        // System RAM write, then a read through a random mirror.
        a = {2'b11, BANK_AW'($urandom)};
        queue_write(a, DATA_W'($urandom));
        queue_read({2'b11, 1'($urandom), a[SYS_AW-1:0]});
      end else if (pick < 55) begin
        slot = $urandom_range(2);
        alt_style = alt_mode[PLAN] ? ($urandom_range(3) != 0) : ($urandom_range(3) == 0);
        case (slot)
          0: a = alt_style ? ADDR_SLOT0 : ADDR_PAGE0;
          1: a = alt_style ? ADDR_SLOT1 : ADDR_PAGE1;
          default: a = alt_style ? ADDR_SLOT2 : ADDR_PAGE2;
        endcase
        queue_write(a, DATA_W'($urandom));
        repeat ($urandom_range(4, 1)) queue_read({2'(slot), BANK_AW'($urandom)});
      end else if (pick < 70) begin
        repeat ($urandom_range(6, 2)) begin
          idx = OFF_W'($urandom);
          if ($urandom_range(1) == 1) begin
            src = map_read(PLAN, {2'($urandom_range(2)), BANK_AW'($urandom)}, idx);
            if (src != SRC_ROM) idx = OFF_W'($urandom);
          end
          queue_load(idx, DATA_W'($urandom));
        end
      end else if (pick < 85) begin
        d = DATA_W'($urandom);
        d[CTRL_RAM_EN] = ($urandom_range(3) != 0);
        queue_write(ADDR_CTRL, d);
        repeat ($urandom_range(6, 2)) begin
          a = {2'b10, BANK_AW'($urandom)};
          if ($urandom_range(1) == 1) queue_write(a, DATA_W'($urandom));
          else queue_read(a);
        end
      end else if (pick < 95) begin
        queue_write(ADDR_W'($urandom), DATA_W'($urandom));
      end else begin
        queue_beat(make_beat(CMD_UNUSED, ADDR_W'($urandom), OFF_W'($urandom),
                             DATA_W'($urandom)));
      end
    end
  endfunction

  function automatic int idle_pct(bit sender_side);
    case (idle_mode)
      IDLE_SEND_LIGHT: return sender_side ? 19 : 79;
      IDLE_SEND_HEAVY: return sender_side ? 79 : 19;
      default:         return 0;
    endcase
  endfunction

  // Now and then a side runs a stretch of cycles without idling at all.
  function automatic bit idle_now(int pct, inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 1'b0;
    end
    if ($urandom_range(199) == 0) quiet = $urandom_range(60, 20);
    return $urandom_range(99) < pct;
  endfunction

  task automatic set_mapper_mode(logic alt, logic wide);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_ALT_MODE;
    cfg_data_i <= alt;
    @(posedge clk_i);
    cfg_index_i <= CFG_ONE_MEG;
    cfg_data_i <= wide;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    alt_mode[PLAN] = alt;
    alt_mode[LIVE] = alt;
    wide_pages[PLAN] = wide;
    wide_pages[LIVE] = wide;
  endtask

  // Writes and loads return nothing, so a final drain wait lets the last ones settle.
  task automatic wait_drained();
    while (pending_beats.size() != 0 || req_bus.valid || read_bytes_due.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive_requests
    bus_beat_t nxt;
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready)
        predict_beat(bus_beat_t'({req_bus.command, req_bus.cpu_address,
                                  req_bus.rom_offset, req_bus.write_data}));
      if (!req_bus.valid || req_bus.ready) begin
        if (pending_beats.size() != 0 && !idle_now(idle_pct(1'b1), send_quiet)) begin
          nxt = pending_beats.pop_front();
          req_bus.valid <= 1'b1;
          req_bus.command <= nxt.command;
          req_bus.cpu_address <= nxt.addr;
          req_bus.rom_offset <= nxt.off;
          req_bus.write_data <= nxt.data;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_responses
    logic [DATA_W-1:0] want;
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (read_bytes_due.size() == 0) begin
          err_count++;
          $display("%0t: read data beat %02h with no read outstanding", $time,
                   rsp_bus.read_data);
        end else begin
          want = read_bytes_due.pop_front();
          if (rsp_bus.read_data !== want) begin
            err_count++;
            $display("%0t: read_data mismatch, expected %02h actual %02h", $time, want,
                     rsp_bus.read_data);
          end
        end
      end
      rsp_bus.ready <= !idle_now(idle_pct(1'b0), recv_quiet);
    end
  end

  initial begin
    req_bus.valid = 1'b0;
    req_bus.command = CMD_READ;
    req_bus.cpu_address = '0;
    req_bus.rom_offset = '0;
    req_bus.write_data = '0;
    rsp_bus.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_ALT_MODE;
    cfg_data_i = 1'b0;
    for (int s = 0; s < 2; s++) begin
      alt_mode[s] = 1'b0;
      wide_pages[s] = 1'b0;
      ctrl_reg[s] = '0;
      page0[s] = PAGE0_RESET;
      page1[s] = PAGE1_RESET;
      page2[s] = PAGE2_RESET;
      bank_sel[s] = 2'b00;
    end
    for (int i = 0; i < CART_BYTES; i++) cart_img[i] = '0;
    for (int i = 0; i < SYS_RAM_BYTES; i++) sys_img[i] = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Standard mode with six-bit pages.
    set_mapper_mode(1'b0, 1'b1);
    queue_load('0, 8'hA5);
    queue_load('1, 8'h5A);
    queue_read(ADDR_SLOT0);
    queue_write(ADDR_PAGE0, 8'hFF);
    queue_read(ADDR_FIXED_END);
    queue_read(ADDR_FIXED_END - 16'd1);
    queue_write(ADDR_PAGE1, 8'hFF);
    queue_read(ADDR_SLOT2 - 16'd1);
    queue_write(ADDR_CTRL, 8'h0C);
    queue_write(16'hBFFF, 8'hFF);
    queue_read(16'hBFFF);
    queue_write(ADDR_PAGE2, 8'h07);
    queue_write(ADDR_CTRL, 8'h00);
    queue_read(ADDR_SLOT2);
    queue_read(ADDR_CTRL);
    queue_write(16'hDFFD, 8'h77);
    queue_read(ADDR_PAGE0);
    queue_read(ADDR_PAGE2);
    queue_write(ADDR_SLOT0, 8'h01);
    queue_read(ADDR_SLOT1);
    queue_beat(make_beat(CMD_UNUSED, '1, '1, '1));
    wait_drained();

    // Alternate paging with five-bit pages.
    set_mapper_mode(1'b1, 1'b0);
    queue_write(ADDR_SLOT0, 8'hFF);
    queue_read(ADDR_SLOT0);
    queue_write(ADDR_SLOT2, 8'hE3);
    queue_write(ADDR_PAGE2, 8'h01);
    queue_read(ADDR_SLOT2);
    queue_read(ADDR_PAGE2);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      set_mapper_mode(p[0], p[0] ^ p[1]);
      idle_mode = idle_mode_e'(p / 2);
      random_traffic(RANDOM_PHASE_BEATS);
    end
    wait_drained();

    if (err_count == 0) begin
      $display("cartridge_bank_mapper_test: PASS");
    end else begin
      $display("cartridge_bank_mapper_test: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout with %0d beats queued and %0d reads outstanding", $time,
             pending_beats.size(), read_bytes_due.size());
    $display("cartridge_bank_mapper_test: FAIL");
    $finish;
  end

endmodule

[cartridge_bank_mapper.f]
+incdir+src
src/cbm_pkg.sv
src/cbm_req_if.sv
src/cbm_rsp_if.sv
src/cbm_ram.sv
src/cbm_clear.sv
src/cbm_map.sv
src/cartridge_bank_mapper.sv
src/cbm_checker.sv
test/cartridge_bank_mapper_test.sv
